/* rtl/core/plbc_pkg.sv */
package plbc_pkg;

   // One polyline vertex, signed Q16.16 meters
   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] l;
   } vertex_type;

   // Interpolation job: position and the segment end points
   typedef struct packed {
      logic signed [31:0] s;
      vertex_type         p0;
      vertex_type         p1;
   } lerp_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lerp_stat_type;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // A boundary needs at least one segment
   localparam int unsigned MIN_VERTICES = 2;

   // Divider retires two quotient bits per cycle over a 32-bit quotient
   localparam int unsigned DIV_CYCLES = 16;
   localparam int unsigned DIV_CNT_W  = 4;

endpackage

/* rtl/core/plbc_vert_mem.sv */
module plbc_vert_mem
   import plbc_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  vertex_type    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output vertex_type    rd_data
);

   vertex_type mem_ff [DEPTH];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/plbc_lerp.sv */
module plbc_lerp
   import plbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lerp_req_type       req,
   output lerp_stat_type      stat,
   output logic signed [31:0] l
);

   typedef enum logic [3:0] {
      LS_IDLE = 4'b0001,
      LS_MUL  = 4'b0010,
      LS_DIV  = 4'b0100,
      LS_DONE = 4'b1000
   } lerp_state_type;

   lerp_state_type state_ff, state_in;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [31:0]          den_ff, num_ff, mag_ff;
   logic                 neg_ff;
   logic signed [31:0]   l0_ff;
   logic [31:0]          rem_ff, shq_ff;

   // Setup terms
   logic signed [32:0] den_w, off_w, dl_w, mag_w;
   logic               degen;
   logic [31:0]        den_sel, num_sel, mag_sel;
   logic [63:0]        prod;

   // Radix-4 restoring step
   logic [32:0] t1, t2;
   logic        ge1, ge2;
   logic [31:0] r1, r2;
   logic signed [32:0] res_w;

   always_comb begin
      den_w = $signed({req.p1.s[31], req.p1.s}) - $signed({req.p0.s[31], req.p0.s});
      off_w = $signed({req.s[31], req.s}) - $signed({req.p0.s[31], req.p0.s});
      dl_w  = $signed({req.p1.l[31], req.p1.l}) - $signed({req.p0.l[31], req.p0.l});
      mag_w = dl_w[32] ? -dl_w : dl_w;
      degen = (req.p1.s <= req.p0.s);
      if (degen) begin
         // zero-length or reversed segment: hold the first vertex
         den_sel = 32'd1;
         num_sel = '0;
         mag_sel = '0;
      end else begin
         den_sel = den_w[31:0];
         mag_sel = mag_w[31:0];
         if (req.s <= req.p0.s) begin
            num_sel = '0;
         end else if (req.s >= req.p1.s) begin
            num_sel = den_w[31:0];
         end else begin
            num_sel = off_w[31:0];
         end
      end
   end

   assign prod = mag_ff * num_ff;

   always_comb begin
      t1  = {rem_ff, shq_ff[31]};
      ge1 = (t1 >= {1'b0, den_ff});
      r1  = ge1 ? 32'(t1 - {1'b0, den_ff}) : t1[31:0];
      t2  = {r1, shq_ff[30]};
      ge2 = (t2 >= {1'b0, den_ff});
      r2  = ge2 ? 32'(t2 - {1'b0, den_ff}) : t2[31:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LS_IDLE: if (start) state_in = LS_MUL;
         LS_MUL:  state_in = LS_DIV;
         LS_DIV:  if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) state_in = LS_DONE;
         LS_DONE: state_in = LS_IDLE;
         default: state_in = LS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LS_IDLE: begin
            if (start) begin
               den_ff <= den_sel;
               num_ff <= num_sel;
               mag_ff <= mag_sel;
               neg_ff <= dl_w[32];
               l0_ff  <= req.p0.l;
            end
         end
         LS_MUL: begin
            // product < den * 2^32, so the high word is already reduced
            rem_ff <= prod[63:32];
            shq_ff <= prod[31:0];
            cnt_ff <= '0;
         end
         LS_DIV: begin
            rem_ff <= r2;
            shq_ff <= {shq_ff[29:0], ge1, ge2};
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign res_w = neg_ff ? $signed({l0_ff[31], l0_ff}) - $signed({1'b0, shq_ff})
                         : $signed({l0_ff[31], l0_ff}) + $signed({1'b0, shq_ff});

   assign l         = res_w[31:0];
   assign stat.idle = (state_ff == LS_IDLE);
   assign stat.done = (state_ff == LS_DONE);

endmodule

/* rtl/core/polyline_lateral_bound_check.sv */
// Lateral bound check of a box against a stored boundary polyline.
//
// Request channel (req_valid / req_stall): req_op selects clear, append or query.
// Clear and append finish in the idle state; append writes the next free vertex slot and
// is dropped once MAX_VERTICES vertices are held. A query returns one beat on the
// response channel (rsp_valid / rsp_stall); clear and append return nothing.
// A query with fewer than two vertices goes straight to the result. Otherwise it reads
// both end vertices and clips the box to them; with no overlap it goes to the result,
// else it streams all n stored vertices through the single read port of the vertex
// memory, then runs two interpolations on one shared multiply/divide unit with a
// 2-bit-per-cycle divider. One query is in flight at a time; req_stall is high while
// it runs.
// The response sits in an output register: a new request is taken while it waits,
// but a second result waits in its final state until rsp_stall drops.
// csr_forbidden_side (csr_valid / csr_ready, always ready) is to be written only while
// idle; the block does not enforce this. Reset clears the vertex count, the side
// register and the response valid flag; the vertex memory is not cleared.
module polyline_lateral_bound_check
   import plbc_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_vertex_s,
   input  logic signed [31:0] req_vertex_l,
   input  logic signed [31:0] req_box_s_min,
   input  logic signed [31:0] req_box_s_max,
   input  logic signed [31:0] req_box_l_min,
   input  logic signed [31:0] req_box_l_max,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_applies,
   output logic               rsp_violates,
   output logic signed [31:0] rsp_limit_l,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_forbidden_side
);

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_RD_FIRST = 10'b0000000010,
      ST_RD_LAST  = 10'b0000000100,
      ST_CLIP     = 10'b0000001000,
      ST_MODE     = 10'b0000010000,
      ST_SCAN     = 10'b0000100000,
      ST_LERP_LO  = 10'b0001000000,
      ST_LERP_HI  = 10'b0010000000,
      ST_COMBINE  = 10'b0100000000,
      ST_RESULT   = 10'b1000000000
   } state_type;

   function automatic logic better(input logic left,
                                   input logic signed [31:0] a,
                                   input logic signed [31:0] b);
      better = left ? (a < b) : (a > b);
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          side_ff;
   logic          rsp_valid_ff;
   logic          rsp_applies_ff, rsp_violates_ff;
   logic signed [31:0] rsp_limit_l_ff;
   logic          launched_ff;
   logic          rd_vld_ff;

   // Query working registers
   logic signed [31:0] s_lo_ff, s_hi_ff, l_min_ff, l_max_ff;
   vertex_type    first_ff, last_ff, prev_ff;
   vertex_type    seg_lo_p0_ff, seg_lo_p1_ff, seg_hi_p0_ff, seg_hi_p1_ff;
   logic          found_lo_ff, found_hi_ff;
   logic          lo_first_ff, lo_last_ff, hi_first_ff, hi_last_ff;
   logic [CW-1:0] iss_ff, rcv_ff;
   logic signed [31:0] int_ff;
   logic          int_vld_ff;
   logic signed [31:0] b_lo_ff, b_hi_ff, ext_ff;
   logic          applies_ff;

   logic          req_accept;
   logic          mem_wr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] last_idx;
   vertex_type    wr_vertex;
   vertex_type    rd_data;
   logic          no_overlap;
   logic          rsp_load;
   logic          lerp_start;
   lerp_req_type  lerp_req;
   lerp_stat_type lerp_stat;
   logic signed [31:0] lerp_l;
   logic          sel_hi, sel_first, sel_last;
   logic signed [31:0] ext_pair, ext_all;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign last_idx   = count_ff - CW'(1);
   assign wr_vertex  = '{s: req_vertex_s, l: req_vertex_l};
   assign no_overlap = (s_hi_ff < first_ff.s) || (s_lo_ff > rd_data.s);
   assign rsp_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      mem_wr     = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      lerp_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_op)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (count_ff < CW'(MAX_VERTICES)) begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_QUERY: begin
                     state_in = (count_ff < CW'(MIN_VERTICES)) ? ST_RESULT : ST_RD_FIRST;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_FIRST: begin
            rd_en    = 1'b1;
            state_in = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx[AW-1:0];
            state_in = ST_CLIP;
         end
         ST_CLIP: state_in = no_overlap ? ST_RESULT : ST_MODE;
         ST_MODE: state_in = ST_SCAN;
         ST_SCAN: begin
            rd_en   = (iss_ff < count_ff);
            rd_addr = iss_ff[AW-1:0];
            if (rcv_ff == count_ff) state_in = ST_LERP_LO;
         end
         ST_LERP_LO: begin
            lerp_start = !launched_ff;
            if (lerp_stat.done) state_in = ST_LERP_HI;
         end
         ST_LERP_HI: begin
            lerp_start = !launched_ff;
            if (lerp_stat.done) state_in = ST_COMBINE;
         end
         ST_COMBINE: state_in = ST_RESULT;
         ST_RESULT:  if (rsp_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // End point source: clamp to an end vertex, else the segment found by the scan
   always_comb begin
      sel_hi    = (state_ff == ST_LERP_HI);
      sel_first = sel_hi ? hi_first_ff : lo_first_ff;
      sel_last  = sel_hi ? hi_last_ff : lo_last_ff;
      lerp_req.s = sel_hi ? s_hi_ff : s_lo_ff;
      if (sel_first) begin
         lerp_req.p0 = first_ff;
         lerp_req.p1 = first_ff;
      end else if (sel_last) begin
         lerp_req.p0 = last_ff;
         lerp_req.p1 = last_ff;
      end else if (sel_hi) begin
         lerp_req.p0 = seg_hi_p0_ff;
         lerp_req.p1 = seg_hi_p1_ff;
      end else begin
         lerp_req.p0 = seg_lo_p0_ff;
         lerp_req.p1 = seg_lo_p1_ff;
      end
   end

   always_comb begin
      ext_pair = better(side_ff, b_hi_ff, b_lo_ff) ? b_hi_ff : b_lo_ff;
      ext_all  = (int_vld_ff && better(side_ff, int_ff, ext_pair)) ? int_ff : ext_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         launched_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= (state_ff == ST_SCAN) && rd_en;
         if (csr_valid && csr_ready) begin
            side_ff <= csr_forbidden_side;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (lerp_start) begin
            launched_ff <= 1'b1;
         end else if (lerp_stat.done) begin
            launched_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_QUERY) begin
               s_lo_ff    <= req_box_s_min;
               s_hi_ff    <= req_box_s_max;
               l_min_ff   <= req_box_l_min;
               l_max_ff   <= req_box_l_max;
               applies_ff <= 1'b0;
               ext_ff     <= '0;
            end
         end
         ST_RD_LAST: first_ff <= rd_data;
         ST_CLIP: begin
            last_ff <= rd_data;
            if (s_lo_ff < first_ff.s) s_lo_ff <= first_ff.s;
            if (s_hi_ff > rd_data.s) s_hi_ff <= rd_data.s;
         end
         ST_MODE: begin
            lo_first_ff <= (s_lo_ff <= first_ff.s);
            lo_last_ff  <= (s_lo_ff >= last_ff.s);
            hi_first_ff <= (s_hi_ff <= first_ff.s);
            hi_last_ff  <= (s_hi_ff >= last_ff.s);
            iss_ff      <= '0;
            rcv_ff      <= '0;
            found_lo_ff <= 1'b0;
            found_hi_ff <= 1'b0;
            int_vld_ff  <= 1'b0;
         end
         ST_SCAN: begin
            if (rd_en) iss_ff <= iss_ff + CW'(1);
            if (rd_vld_ff) begin
               // interior vertices strictly inside the clipped range
               if (rd_data.s > s_lo_ff && rd_data.s < s_hi_ff &&
                   (!int_vld_ff || better(side_ff, rd_data.l, int_ff))) begin
                  int_ff     <= rd_data.l;
                  int_vld_ff <= 1'b1;
               end
               // first segment whose far end reaches the point
               if (rcv_ff != '0) begin
                  if (!found_lo_ff && s_lo_ff <= rd_data.s) begin
                     seg_lo_p0_ff <= prev_ff;
                     seg_lo_p1_ff <= rd_data;
                     found_lo_ff  <= 1'b1;
                  end
                  if (!found_hi_ff && s_hi_ff <= rd_data.s) begin
                     seg_hi_p0_ff <= prev_ff;
                     seg_hi_p1_ff <= rd_data;
                     found_hi_ff  <= 1'b1;
                  end
               end
               prev_ff <= rd_data;
               rcv_ff  <= rcv_ff + CW'(1);
            end
         end
         ST_LERP_LO: if (lerp_stat.done) b_lo_ff <= lerp_l;
         ST_LERP_HI: if (lerp_stat.done) b_hi_ff <= lerp_l;
         ST_COMBINE: begin
            ext_ff     <= ext_all;
            applies_ff <= 1'b1;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_applies_ff  <= applies_ff;
               rsp_violates_ff <= applies_ff &&
                                  (side_ff ? (l_max_ff > ext_ff) : (l_min_ff < ext_ff));
               rsp_limit_l_ff  <= ext_ff;
            end
         end
         default: ;
      endcase
   end

   plbc_vert_mem #(
      .DEPTH (MAX_VERTICES),
      .AW    (AW)
   ) u_vert_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_vertex),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plbc_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .req   (lerp_req),
      .stat  (lerp_stat),
      .l     (lerp_l)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_applies  = rsp_applies_ff;
   assign rsp_violates = rsp_violates_ff;
   assign rsp_limit_l  = rsp_limit_l_ff;

   a_full_append_dropped: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_op == OP_APPEND && count_ff == CW'(MAX_VERTICES)
      |=> count_ff == CW'(MAX_VERTICES))
      else $error("append past capacity changed the vertex count");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
      else $error("response raised outside the result state");

   a_lerp_start_idle: assert property (@(posedge clock) disable iff (reset)
      lerp_start |-> lerp_stat.idle)
      else $error("interpolation launched while busy");

   a_not_applying_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_applies_ff |-> rsp_limit_l_ff == '0 && !rsp_violates_ff)
      else $error("non-applying response carries a bound or violation");

endmodule
